@@ src/modbus_read_response_parser_assert.svh @@
// Assertion macros shared by the parser checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef MODBUS_READ_RESPONSE_PARSER_ASSERT_SVH
`define MODBUS_READ_RESPONSE_PARSER_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define MRRP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrrp checker: property failed");

// next-cycle implication, quiet while reset is held
`define MRRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mrrp checker: property failed");

`endif

@@ src/mrrp_pkg.sv @@
// Types and constants of the Modbus read response parser.
// No dependencies; used by every module of the block.
`default_nettype none

package mrrp_pkg;

	localparam logic [9:0] HDR_LEN           = 10'd9;
	localparam logic [8:0] POS_MAX           = 9'd264;
	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSACTION_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_ID        = 2'd1;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_TOO_SHORT  = 2'd1,
		STATUS_BAD_HEADER = 2'd2,
		STATUS_BAD_COUNT  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} mrrp_in_t;

	typedef struct packed {
		logic [15:0] reg_value;
		logic        is_status;
		logic [1:0]  status_code;
		logic        run_end;
	} mrrp_out_t;

	// work handed from the parser to the output sequencer
	typedef struct packed {
		logic        word_valid;
		logic [15:0] word;
		logic        status_valid;
		status_t     code;
	} mrrp_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mrrp_queue_status_t;

endpackage

`default_nettype wire

@@ src/mrrp_front.sv @@
// Front end: holds configuration, tracks the frame position and classifies each byte.
// Pushes word/status entries into the result queue. Uses mrrp_pkg.
`default_nettype none

module mrrp_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  mrrp_pkg::mrrp_in_t                   in_data,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [mrrp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [15:0]                          cfg_data,
	input  mrrp_pkg::mrrp_queue_status_t         q_status,
	output logic                                 push,
	output mrrp_pkg::mrrp_entry_t                push_entry
);

	logic [15:0] exp_tid_q;
	logic [7:0]  exp_unit_q;
	logic [8:0]  pos_q;
	logic        header_bad_q;
	logic [7:0]  count_q;
	logic [7:0]  held_q;

	logic        accept;
	logic        hb_next;
	logic [7:0]  count_next;
	logic [7:0]  held_next;
	logic        word_v;
	logic [9:0]  body_end;
	logic [9:0]  body_end_next;
	logic [9:0]  total;
	logic [7:0]  b;
	mrrp_pkg::status_t code;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_status.full;
	assign accept    = in_valid && !in_stall;
	assign b         = in_data.frame_byte;
	assign body_end  = mrrp_pkg::HDR_LEN + {2'b00, count_q};
	assign total     = {1'b0, pos_q} + 10'd1;

	always_comb begin
		hb_next    = header_bad_q;
		count_next = count_q;
		held_next  = held_q;
		word_v     = 1'b0;
		case (pos_q)
			9'd0: held_next = b;
			9'd1: if ({held_q, b} != exp_tid_q) hb_next = 1'b1;
			9'd6: if (b != exp_unit_q) hb_next = 1'b1;
			9'd7: if (b != mrrp_pkg::FUNC_READ_HOLDING) hb_next = 1'b1;
			9'd8: count_next = b;
			default: begin
				if ({1'b0, pos_q} >= mrrp_pkg::HDR_LEN && {1'b0, pos_q} < body_end) begin
					// header length is odd: odd positions carry the high byte
					if (pos_q[0]) begin
						held_next = b;
					end else if (!header_bad_q && !count_q[0]) begin
						word_v = 1'b1;
					end
				end
			end
		endcase
	end

	assign body_end_next = mrrp_pkg::HDR_LEN + {2'b00, count_next};

	always_comb begin
		if (total < mrrp_pkg::HDR_LEN) begin
			code = mrrp_pkg::STATUS_TOO_SHORT;
		end else if (hb_next) begin
			code = mrrp_pkg::STATUS_BAD_HEADER;
		end else if (count_next[0] || total < body_end_next) begin
			code = mrrp_pkg::STATUS_BAD_COUNT;
		end else begin
			code = mrrp_pkg::STATUS_OK;
		end
	end

	assign push = accept && (word_v || in_data.frame_end);
	assign push_entry = '{
		word_valid:   word_v,
		word:         {held_q, b},
		status_valid: in_data.frame_end,
		code:         code
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_tid_q    <= '0;
			exp_unit_q   <= '0;
			pos_q        <= '0;
			header_bad_q <= 1'b0;
			count_q      <= '0;
			held_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mrrp_pkg::CFG_TRANSACTION_ID) exp_tid_q <= cfg_data;
				if (cfg_index == mrrp_pkg::CFG_UNIT_ID) exp_unit_q <= cfg_data[7:0];
			end
			if (accept) begin
				if (in_data.frame_end) begin
					pos_q        <= '0;
					header_bad_q <= 1'b0;
					count_q      <= '0;
					held_q       <= '0;
				end else begin
					if (pos_q < mrrp_pkg::POS_MAX) pos_q <= pos_q + 9'd1;
					header_bad_q <= hb_next;
					count_q      <= count_next;
					held_q       <= held_next;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ src/mrrp_queue.sv @@
// Short result queue between the parser front end and the output sequencer.
// Register-based FIFO of mrrp_entry_t; uses mrrp_pkg.
`default_nettype none

module mrrp_queue (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           push,
	input  mrrp_pkg::mrrp_entry_t         push_entry,
	input  wire                           pop,
	output mrrp_pkg::mrrp_entry_t         head,
	output mrrp_pkg::mrrp_queue_status_t  status
);

	localparam int unsigned AW = mrrp_pkg::QUEUE_AW;

	mrrp_pkg::mrrp_entry_t entries_q [mrrp_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   fill_q;
	logic          do_push;
	logic          do_pop;

	assign status.full  = (fill_q == (AW+1)'(mrrp_pkg::QUEUE_DEPTH));
	assign status.empty = (fill_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + AW'(1);
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + (AW+1)'(1);
				2'b01:   fill_q <= fill_q - (AW+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/mrrp_back.sv @@
// Output sequencer: turns queue entries into result beats, word before status.
// Owns the output register; uses mrrp_pkg.
`default_nettype none

module mrrp_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  mrrp_pkg::mrrp_entry_t         head,
	input  mrrp_pkg::mrrp_queue_status_t  q_status,
	output logic                          pop,
	output logic                          out_valid,
	input  wire                           out_stall,
	output mrrp_pkg::mrrp_out_t           out_data
);

	logic                  out_valid_q;
	mrrp_pkg::mrrp_out_t   out_q;
	logic                  pend_q;
	mrrp_pkg::status_t     pend_code_q;
	logic                  load;

	function automatic mrrp_pkg::mrrp_out_t status_beat(mrrp_pkg::status_t c);
		mrrp_pkg::mrrp_out_t r;
		r.reg_value   = '0;
		r.is_status   = 1'b1;
		r.status_code = c;
		r.run_end     = 1'b1;
		return r;
	endfunction

	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && !pend_q && !q_status.empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
			pend_q      <= 1'b0;
			pend_code_q <= mrrp_pkg::STATUS_OK;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				out_q       <= status_beat(pend_code_q);
				pend_q      <= 1'b0;
			end else if (!q_status.empty) begin
				out_valid_q <= 1'b1;
				if (head.word_valid) begin
					out_q.reg_value   <= head.word;
					out_q.is_status   <= 1'b0;
					out_q.status_code <= mrrp_pkg::STATUS_OK;
					out_q.run_end     <= 1'b0;
					// status of the same byte goes out on the following beat
					pend_q      <= head.status_valid;
					pend_code_q <= head.code;
				end else begin
					out_q <= status_beat(head.code);
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/modbus_read_response_parser.sv @@
// Modbus TCP read holding registers response parser, top level.
// Takes one frame byte per input beat (frame_end on the last byte) and returns
// register words and one closing status per frame.
// Channels: in (in_valid/in_stall/in_data), out (out_valid/out_stall/out_data),
// and a configuration write port (cfg_valid/cfg_ready, cfg_index, cfg_data):
// index 0 is the expected transaction id, index 1 the expected unit id in
// cfg_data[7:0]; other indexes are ignored. cfg_ready is always high.
// A result is written into the queue on the edge that accepts its byte and is
// then loaded into the output register, which presents it on out.
// One byte is taken per cycle while in_stall is low; a last byte that also
// completes a word yields two beats, word then status.
// The parser front end and the output register are parted by a four-entry
// result queue; in_stall rises only when that queue is full, which happens
// only while the receiver stalls out.
// Reset (arst_n low) clears the configuration to zero, the frame state, the
// queue and the output register. A stalled result holds on out_data.
// Uses mrrp_pkg, mrrp_front, mrrp_queue and mrrp_back.
`default_nettype none

module modbus_read_response_parser (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  mrrp_pkg::mrrp_in_t               in_data,
	output logic                             out_valid,
	input  wire                              out_stall,
	output mrrp_pkg::mrrp_out_t              out_data,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [mrrp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [15:0]                      cfg_data
);

	mrrp_pkg::mrrp_queue_status_t q_status;
	mrrp_pkg::mrrp_entry_t        push_entry;
	mrrp_pkg::mrrp_entry_t        head;
	logic                         push;
	logic                         pop;

	mrrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	mrrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	mrrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

@@ src/mrrp_checker.sv @@
// Port-level checker for the parser, bound to the top level.
// Uses mrrp_pkg and the macros of modbus_read_response_parser_assert.svh.
`default_nettype none

`include "modbus_read_response_parser_assert.svh"

module mrrp_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	input  wire                              in_stall,
	input  mrrp_pkg::mrrp_in_t               in_data,
	input  wire                              out_valid,
	input  wire                              out_stall,
	input  mrrp_pkg::mrrp_out_t              out_data
);

	// a stalled result beat stays up and unchanged
	`MRRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// a stalled input beat stays up and unchanged
	`MRRP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

	// a status beat closes the frame and carries no word
	`MRRP_ASSERT_NOW(a_status_shape, out_valid && out_data.is_status,
		out_data.run_end && out_data.reg_value == 16'd0)

	// a word beat never closes the frame and carries no code
	`MRRP_ASSERT_NOW(a_word_shape, out_valid && !out_data.is_status,
		!out_data.run_end && out_data.status_code == mrrp_pkg::STATUS_OK)

	// input back-pressure only appears while output work is waiting
	`MRRP_ASSERT_NOW(a_stall_cause, in_stall, out_valid)

endmodule

bind modbus_read_response_parser mrrp_checker u_checker (.*);

`default_nettype wire
